/* sv/tgarle_pkg.sv */
// ----------------------------------------------------------------------------
// tgarle_pkg
// Shared types and constants of the run-length TGA pixel decoder.
// ----------------------------------------------------------------------------
package tgarle_pkg;

  // field widths
  localparam int INDEX_BITS  = 24;
  localparam int PIXEL_BITS  = 32;
  localparam int BPP_BITS    = 3;
  localparam int TOTAL_BITS  = 25;
  localparam int RUN_BITS    = 8;
  localparam int CFG_DATA_BITS = 25;

  // command queue between front and back
  localparam int QUEUE_DEPTH    = 4;
  localparam int QUEUE_PTR_BITS = 2;
  localparam int QUEUE_CNT_BITS = 3;

  // register reset values
  localparam logic [BPP_BITS-1:0]   BPP_RESET   = 3'd4;
  localparam logic [TOTAL_BITS-1:0] TOTAL_RESET = 25'd1;

  // packet header coding
  localparam logic [7:0] HEADER_SPLIT = 8'd128;
  localparam logic [7:0] REPEAT_BIAS  = 8'd127;

  // configuration register indexes
  typedef enum logic [0:0] {
    REG_BYTES_PER_PIXEL = 1'b0,
    REG_TOTAL_PIXELS    = 1'b1
  } cfg_reg_t;

  // work handed from front to back
  typedef enum logic [1:0] {
    CMD_FLUSH = 2'd0,   // repeat header: send a held pixel alone
    CMD_PLACE = 2'd1,   // place count copies of pixel from pos on
    CMD_ERROR = 2'd2    // excess pixel: error result, drop held pixel
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t               kind;
    logic [PIXEL_BITS-1:0]   pixel;
    logic [TOTAL_BITS-1:0]   pos;
    logic [RUN_BITS-1:0]     count;
    logic                    overflow;
  } cmd_t;

  // live configuration
  typedef struct packed {
    logic [BPP_BITS-1:0]   bpp;
    logic [TOTAL_BITS-1:0] total;
  } cfg_t;

  // one result item, index at full position width
  typedef struct packed {
    logic [PIXEL_BITS-1:0] first_pixel;
    logic [PIXEL_BITS-1:0] second_pixel;
    logic [1:0]            pixels_valid;
    logic [TOTAL_BITS-1:0] pixel_index;
    logic                  run_last;
    logic                  image_done;
    logic                  overflow_error;
  } result_t;

endpackage

/* sv/tgarle_front.sv */
// ----------------------------------------------------------------------------
// tgarle_front
// Parses packet headers, gathers pixel bytes and counts placed pixels;
// issues one command per repeat header or finished pixel into the queue.
// ----------------------------------------------------------------------------
module tgarle_front (
  input  logic                              clk,
  input  logic                              rst,
  input  logic [7:0]                        data_byte,
  input  logic                              byte_valid,
  output logic                              byte_ready,
  input  tgarle_pkg::cfg_t                  cfg,
  input  logic                              queue_full,
  output logic                              push,
  output tgarle_pkg::cmd_t                  push_cmd
);

  typedef enum logic [2:0] {
    PH_HEADER = 3'b001,
    PH_RAW    = 3'b010,
    PH_REPEAT = 3'b100
  } phase_t;

  phase_t                                  phase, phase_next;
  logic [tgarle_pkg::RUN_BITS-1:0]         remaining, remaining_next;
  logic [1:0]                              byte_pos, byte_pos_next;
  logic [tgarle_pkg::PIXEL_BITS-1:0]       assembly, assembly_next;
  logic [tgarle_pkg::TOTAL_BITS-1:0]       written, written_next;

  logic                                    accept;
  logic [tgarle_pkg::BPP_BITS-1:0]         bpp_eff;
  logic [tgarle_pkg::PIXEL_BITS-1:0]       pixel_word;
  logic [2:0]                              pos_after;
  logic                                    pixel_done;
  logic                                    at_limit;
  logic [tgarle_pkg::TOTAL_BITS-1:0]       avail;
  logic                                    rep_over;
  logic [tgarle_pkg::RUN_BITS-1:0]         rep_count;
  logic [tgarle_pkg::RUN_BITS-1:0]         raw_left;
  logic [tgarle_pkg::TOTAL_BITS:0]         written_raw;
  logic [tgarle_pkg::TOTAL_BITS:0]         written_rep;
  logic [tgarle_pkg::TOTAL_BITS:0]         total_wide;

  // one byte per cycle while the queue has room for a command
  assign byte_ready = !queue_full;
  assign accept     = byte_valid && byte_ready;

  // pixel size clamped to one..four bytes
  always_comb begin
    case (cfg.bpp)
      3'd0:    bpp_eff = 3'd1;
      3'd1:    bpp_eff = 3'd1;
      3'd2:    bpp_eff = 3'd2;
      3'd3:    bpp_eff = 3'd3;
      3'd4:    bpp_eff = 3'd4;
      default: bpp_eff = 3'd4;
    endcase
  end

  // byte gathering and pixel budget
  assign pixel_word  = assembly | (tgarle_pkg::PIXEL_BITS'(data_byte) << {byte_pos, 3'b000});
  assign pos_after   = {1'b0, byte_pos} + 3'd1;
  assign pixel_done  = (pos_after >= bpp_eff);
  assign at_limit    = (written >= cfg.total);
  assign avail       = at_limit ? '0 : (cfg.total - written);
  assign rep_over    = (tgarle_pkg::TOTAL_BITS'(remaining) > avail);
  assign rep_count   = rep_over ? avail[tgarle_pkg::RUN_BITS-1:0] : remaining;
  assign raw_left    = (remaining != '0) ? (remaining - 8'd1) : '0;
  assign written_raw = {1'b0, written} + 26'd1;
  assign written_rep = {1'b0, written} + (tgarle_pkg::TOTAL_BITS+1)'(remaining);
  assign total_wide  = {1'b0, cfg.total};

  // next state and command
  always_comb begin
    phase_next     = phase;
    remaining_next = remaining;
    byte_pos_next  = byte_pos;
    assembly_next  = assembly;
    written_next   = written;
    push           = 1'b0;
    push_cmd       = '{kind: tgarle_pkg::CMD_PLACE, pixel: pixel_word, pos: written,
                       count: 8'd1, overflow: 1'b0};
    if (accept) begin
      case (phase)
        PH_RAW, PH_REPEAT: begin
          if (!pixel_done) begin
            assembly_next = pixel_word;
            byte_pos_next = pos_after[1:0];
          end else begin
            assembly_next = '0;
            byte_pos_next = '0;
            push          = 1'b1;
            if (phase == PH_RAW) begin
              remaining_next = raw_left;
              if (at_limit) begin
                // excess pixel: error and start a new image
                push_cmd.kind  = tgarle_pkg::CMD_ERROR;
                phase_next     = PH_HEADER;
                remaining_next = '0;
                written_next   = '0;
              end else begin
                written_next = written_raw[tgarle_pkg::TOTAL_BITS-1:0];
                if (raw_left == '0) begin
                  phase_next = PH_HEADER;
                  if (written_raw >= total_wide) begin
                    written_next = '0;
                  end
                end
              end
            end else begin
              // repeat run, cut at the image end
              push_cmd.kind     = (rep_count == '0) ? tgarle_pkg::CMD_ERROR
                                                    : tgarle_pkg::CMD_PLACE;
              push_cmd.count    = rep_count;
              push_cmd.overflow = rep_over;
              phase_next        = PH_HEADER;
              remaining_next    = '0;
              if (rep_over || (written_rep >= total_wide)) begin
                written_next = '0;
              end else begin
                written_next = written_rep[tgarle_pkg::TOTAL_BITS-1:0];
              end
            end
          end
        end
        default: begin
          // packet header
          byte_pos_next = '0;
          assembly_next = '0;
          if (data_byte < tgarle_pkg::HEADER_SPLIT) begin
            phase_next     = PH_RAW;
            remaining_next = data_byte + 8'd1;
          end else begin
            phase_next     = PH_REPEAT;
            remaining_next = data_byte - tgarle_pkg::REPEAT_BIAS;
            push           = 1'b1;
            push_cmd.kind  = tgarle_pkg::CMD_FLUSH;
          end
        end
      endcase
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_HEADER;
      remaining <= '0;
      byte_pos  <= '0;
      assembly  <= '0;
      written   <= '0;
    end else begin
      phase     <= phase_next;
      remaining <= remaining_next;
      byte_pos  <= byte_pos_next;
      assembly  <= assembly_next;
      written   <= written_next;
    end
  end

  // a command goes out only where the queue takes it
  a_push_room: assert property (@(posedge clk) disable iff (rst) push |-> !queue_full)
    else $error("front pushed into a full queue");
  // a header never carries pixel bytes over
  a_header_clean: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_HEADER) |-> (byte_pos == '0 && assembly == '0))
    else $error("pixel bytes left over at a header");
  // a finished pixel always issues a command
  a_pixel_cmd: assert property (@(posedge clk) disable iff (rst)
    (accept && phase != PH_HEADER && pixel_done) |-> push)
    else $error("finished pixel issued no command");

endmodule

/* sv/tgarle_queue.sv */
// ----------------------------------------------------------------------------
// tgarle_queue
// Short command queue between the front and the back.
// ----------------------------------------------------------------------------
module tgarle_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  tgarle_pkg::cmd_t push_cmd,
  output logic             full,
  input  logic             pop,
  output logic             head_valid,
  output tgarle_pkg::cmd_t head_cmd
);

  tgarle_pkg::cmd_t                      entries [tgarle_pkg::QUEUE_DEPTH];
  logic [tgarle_pkg::QUEUE_PTR_BITS-1:0] wr_ptr, rd_ptr;
  logic [tgarle_pkg::QUEUE_CNT_BITS-1:0] fill;

  // status
  assign full       = (fill == tgarle_pkg::QUEUE_CNT_BITS'(tgarle_pkg::QUEUE_DEPTH));
  assign head_valid = (fill != '0);
  assign head_cmd   = entries[rd_ptr];

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + tgarle_pkg::QUEUE_PTR_BITS'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + tgarle_pkg::QUEUE_PTR_BITS'(1);
      end
      case ({push, pop})
        2'b10:   fill <= fill + tgarle_pkg::QUEUE_CNT_BITS'(1);
        2'b01:   fill <= fill - tgarle_pkg::QUEUE_CNT_BITS'(1);
        default: fill <= fill;
      endcase
    end
  end

  // no pop from an empty queue
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst) pop |-> head_valid)
    else $error("pop from an empty queue");
  // fill count stays within depth
  a_fill_range: assert property (@(posedge clk) disable iff (rst)
    fill <= tgarle_pkg::QUEUE_CNT_BITS'(tgarle_pkg::QUEUE_DEPTH))
    else $error("queue fill count out of range");
  // fill count follows the requests
  a_fill_track: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> (fill == $past(fill) + tgarle_pkg::QUEUE_CNT_BITS'(1)))
    else $error("queue fill count lost a push");

endmodule

/* sv/tgarle_back.sv */
// ----------------------------------------------------------------------------
// tgarle_back
// Carries out queued commands: pairs pixels, expands repeat runs and
// fills the output register, one result per cycle while it is free.
// ----------------------------------------------------------------------------
module tgarle_back (
  input  logic                              clk,
  input  logic                              rst,
  input  logic [tgarle_pkg::TOTAL_BITS-1:0] total_pixels,
  input  logic                              head_valid,
  input  tgarle_pkg::cmd_t                  head_cmd,
  output logic                              pop,
  output logic                              result_valid,
  input  logic                              result_ready,
  output tgarle_pkg::result_t               result
);

  typedef enum logic [1:0] {
    BK_IDLE = 2'b01,
    BK_RUN  = 2'b10
  } back_state_t;

  back_state_t                         state, state_next;
  tgarle_pkg::cmd_kind_t               kind, kind_next;
  logic [tgarle_pkg::PIXEL_BITS-1:0]   pixel, pixel_next;
  logic [tgarle_pkg::TOTAL_BITS-1:0]   pos, pos_next;
  logic [tgarle_pkg::RUN_BITS-1:0]     left, left_next;
  logic                                over, over_next;
  logic [tgarle_pkg::PIXEL_BITS-1:0]   held_pixel, held_pixel_next;
  logic                                held_valid, held_valid_next;

  logic                                slot_free;
  logic                                emit;
  tgarle_pkg::result_t                 emit_result;
  logic [tgarle_pkg::TOTAL_BITS:0]     pos_plus1, pos_plus2, next_plus1, total_wide;
  logic                                done;

  assign slot_free  = !result_valid || result_ready;
  assign total_wide = {1'b0, total_pixels};
  assign pos_plus1  = {1'b0, pos} + 26'd1;
  assign pos_plus2  = {1'b0, pos} + 26'd2;
  assign next_plus1 = {1'b0, pos_next} + 26'd1;

  // command execution
  always_comb begin
    state_next      = state;
    kind_next       = kind;
    pixel_next      = pixel;
    pos_next        = pos;
    left_next       = left;
    over_next       = over;
    held_pixel_next = held_pixel;
    held_valid_next = held_valid;
    pop             = 1'b0;
    emit            = 1'b0;
    done            = 1'b0;
    emit_result     = '{first_pixel: pixel, second_pixel: pixel, pixels_valid: 2'd2,
                        pixel_index: pos, run_last: 1'b1, image_done: 1'b0,
                        overflow_error: 1'b0};
    case (state)
      BK_RUN: begin
        if (slot_free) begin
          case (kind)
            tgarle_pkg::CMD_PLACE: begin
              if (held_valid) begin
                // held pixel pairs with the first copy
                done                     = (pos_plus1 == total_wide);
                emit                     = 1'b1;
                emit_result.first_pixel  = held_pixel;
                emit_result.pixel_index  = pos - 25'd1;
                pos_next                 = pos_plus1[tgarle_pkg::TOTAL_BITS-1:0];
                left_next                = left - 8'd1;
                held_valid_next          = 1'b0;
                held_pixel_next          = '0;
              end else if (left >= 8'd2) begin
                done      = (pos_plus2 == total_wide);
                emit      = 1'b1;
                pos_next  = pos_plus2[tgarle_pkg::TOTAL_BITS-1:0];
                left_next = left - 8'd2;
              end else begin
                // single copy: final pixel goes alone, otherwise held
                if (pos_plus1 == total_wide) begin
                  done                     = 1'b1;
                  emit                     = 1'b1;
                  emit_result.second_pixel = '0;
                  emit_result.pixels_valid = 2'd1;
                end else begin
                  held_pixel_next = pixel;
                  held_valid_next = 1'b1;
                end
                pos_next  = pos_plus1[tgarle_pkg::TOTAL_BITS-1:0];
                left_next = '0;
              end
              emit_result.image_done     = done;
              emit_result.overflow_error = over && done;
              emit_result.run_last       = (left_next == '0) ||
                                           (left_next == 8'd1 && next_plus1 != total_wide);
              if (left_next == '0) begin
                state_next = BK_IDLE;
              end
            end
            tgarle_pkg::CMD_FLUSH: begin
              if (held_valid) begin
                emit                     = 1'b1;
                emit_result.first_pixel  = held_pixel;
                emit_result.second_pixel = '0;
                emit_result.pixels_valid = 2'd1;
                emit_result.pixel_index  = pos - 25'd1;
              end
              held_valid_next = 1'b0;
              held_pixel_next = '0;
              state_next      = BK_IDLE;
            end
            tgarle_pkg::CMD_ERROR: begin
              emit                       = 1'b1;
              emit_result.first_pixel    = '0;
              emit_result.second_pixel   = '0;
              emit_result.pixels_valid   = 2'd0;
              emit_result.overflow_error = 1'b1;
              held_valid_next            = 1'b0;
              held_pixel_next            = '0;
              state_next                 = BK_IDLE;
            end
            default: begin
              state_next = BK_IDLE;
            end
          endcase
        end
      end
      default: begin
        // fetch the next command
        if (head_valid) begin
          pop        = 1'b1;
          kind_next  = head_cmd.kind;
          pixel_next = head_cmd.pixel;
          pos_next   = head_cmd.pos;
          left_next  = head_cmd.count;
          over_next  = head_cmd.overflow;
          state_next = BK_RUN;
        end
      end
    endcase
  end

  // working registers
  always_ff @(posedge clk) begin
    kind  <= kind_next;
    pixel <= pixel_next;
    pos   <= pos_next;
    left  <= left_next;
    over  <= over_next;
    if (emit) begin
      result <= emit_result;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= BK_IDLE;
      held_valid   <= 1'b0;
      held_pixel   <= '0;
      result_valid <= 1'b0;
    end else begin
      state      <= state_next;
      held_valid <= held_valid_next;
      held_pixel <= held_pixel_next;
      if (emit) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  // a result with no pixels is always an error result
  a_empty_is_error: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.pixels_valid == 2'd0) |-> result.overflow_error)
    else $error("result without pixels lacks the error flag");
  // second pixel is zero unless a pair is sent
  a_second_zero: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.pixels_valid != 2'd2) |-> (result.second_pixel == '0))
    else $error("unpaired result carries a second pixel");
  // an image end always carries a pixel
  a_done_has_pixel: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.image_done) |-> (result.pixels_valid != 2'd0))
    else $error("image end without a pixel");
  // a new result only replaces one that is taken
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result_ready) |=> (result_valid && $stable(result)))
    else $error("pending result overwritten");

endmodule

/* sv/tga_rle_pixel_decoder_core.sv */
// ----------------------------------------------------------------------------
// tga_rle_pixel_decoder_core
// Run-length TGA pixel decoder: compressed bytes in, pixel pairs out.
// ----------------------------------------------------------------------------
//
//  channel   signals                                   request
//  -------   ---------------------------------------   -----------------------
//  bytes     byte_valid / byte_ready, data_byte         one stream byte
//  results   result_valid / result_ready, pixel fields  up to two pixels
//  config    cfg_valid / cfg_ready, cfg_index, cfg_data one register write
//
// A byte is taken whenever the four-entry command queue has room.
// The back fetches a command and then sends one result per cycle while the
// output register is free, sending a repeat run as pixel pairs.
// Reset clears all control state; registers return to 4 bytes and 1 pixel.
// A stalled result holds the output register; a full queue drops byte_ready.
// Config writes are always taken and apply at once.
// ----------------------------------------------------------------------------
module tga_rle_pixel_decoder_core #(
  parameter int INDEX_BITS = tgarle_pkg::INDEX_BITS
) (
  input  logic                                 clk,
  input  logic                                 rst,
  // stream bytes
  input  logic                                 byte_valid,
  output logic                                 byte_ready,
  input  logic [7:0]                           data_byte,
  // results
  output logic                                 result_valid,
  input  logic                                 result_ready,
  output logic [tgarle_pkg::PIXEL_BITS-1:0]    first_pixel,
  output logic [tgarle_pkg::PIXEL_BITS-1:0]    second_pixel,
  output logic [1:0]                           pixels_valid,
  output logic [INDEX_BITS-1:0]                pixel_index,
  output logic                                 run_last,
  output logic                                 image_done,
  output logic                                 overflow_error,
  // configuration writes
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [0:0]                           cfg_index,
  input  logic [tgarle_pkg::CFG_DATA_BITS-1:0] cfg_data
);

  tgarle_pkg::cfg_t    cfg;
  logic                queue_full;
  logic                push;
  tgarle_pkg::cmd_t    push_cmd;
  logic                pop;
  logic                head_valid;
  tgarle_pkg::cmd_t    head_cmd;
  tgarle_pkg::result_t result;

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.bpp   <= tgarle_pkg::BPP_RESET;
      cfg.total <= tgarle_pkg::TOTAL_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (tgarle_pkg::cfg_reg_t'(cfg_index))
        tgarle_pkg::REG_BYTES_PER_PIXEL: cfg.bpp   <= cfg_data[tgarle_pkg::BPP_BITS-1:0];
        tgarle_pkg::REG_TOTAL_PIXELS:    cfg.total <= cfg_data[tgarle_pkg::TOTAL_BITS-1:0];
        default:                         cfg       <= cfg;
      endcase
    end
  end

  // header parsing and byte gathering
  tgarle_front u_front (
    .clk        (clk),
    .rst        (rst),
    .data_byte  (data_byte),
    .byte_valid (byte_valid),
    .byte_ready (byte_ready),
    .cfg        (cfg),
    .queue_full (queue_full),
    .push       (push),
    .push_cmd   (push_cmd)
  );

  // command queue
  tgarle_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_cmd   (push_cmd),
    .full       (queue_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_cmd   (head_cmd)
  );

  // run expansion and output register
  tgarle_back u_back (
    .clk          (clk),
    .rst          (rst),
    .total_pixels (cfg.total),
    .head_valid   (head_valid),
    .head_cmd     (head_cmd),
    .pop          (pop),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  // result fields
  assign first_pixel    = result.first_pixel;
  assign second_pixel   = result.second_pixel;
  assign pixels_valid   = result.pixels_valid;
  assign pixel_index    = INDEX_BITS'(result.pixel_index);
  assign run_last       = result.run_last;
  assign image_done     = result.image_done;
  assign overflow_error = result.overflow_error;

endmodule
